### rtl/core/lifo_stack_engine_core_assert.svh
// ----------------------------------------------------------------------------
// lifo stack engine assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as reset
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_ENGINE_CORE_ASSERT_SVH
`define LIFO_STACK_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define LSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// shared constants, operation codes and the result record of the stack engine
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned RCOUNT_W  = 9;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RCOUNT_W-1:0] found;
    logic                empty;
    logic [RCOUNT_W-1:0] count;
    logic [WORD_W-1:0]   bottom;
    logic [WORD_W-1:0]   top;
  } lse_res_t;

endpackage

### rtl/core/lse_ram.sv
// ----------------------------------------------------------------------------
// lse_ram
// generic single-write, single-read ram with a registered read port
// ----------------------------------------------------------------------------
module lse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl
// stack sequencer: fill count, cached top and bottom words, word store access
// ----------------------------------------------------------------------------
`include "lifo_stack_engine_core_assert.svh"

module lse_ctrl #(
  parameter int unsigned STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [lse_pkg::MODE_W-1:0]  mode_i,
  input  logic [lse_pkg::WORD_W-1:0]  value_i,
  output logic                        idle_o,
  output logic                        done_o,
  output lse_pkg::lse_res_t           res_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_POP    = 3'b010,
    S_SEARCH = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [lse_pkg::WORD_W-1:0] top_r, top_nxt;
  logic [lse_pkg::WORD_W-1:0] bottom_r, bottom_nxt;
  logic [lse_pkg::WORD_W-1:0] key_r, key_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [lse_pkg::WORD_W-1:0]   rd_data;
  logic [CW-1:0]                found;
  logic [lse_pkg::STATUS_W-1:0] status;
  logic                         done;

  lse_ram #(
    .WIDTH (lse_pkg::WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_i),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    key_nxt    = key_r;
    addr_nxt   = addr_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    found      = '0;
    status     = lse_pkg::ST_OK;
    done       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          key_nxt = value_i;
          case (mode_i)
            lse_pkg::MODE_PUSH: begin
              done = 1'b1;
              if (count_r == CW'(STACK_DEPTH)) begin
                status = lse_pkg::ST_OVER;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                top_nxt   = value_i;
                if (count_r == '0) begin
                  bottom_nxt = value_i;
                end
              end
            end
            lse_pkg::MODE_POP: begin
              if (count_r == '0) begin
                status = lse_pkg::ST_UNDER;
                done   = 1'b1;
              end else begin
                count_nxt = count_r - CW'(1);
                if (count_r == CW'(1)) begin
                  done = 1'b1;
                end else begin
                  // fetch the word that becomes the new top
                  rd_en     = 1'b1;
                  rd_addr   = AW'(count_r - CW'(2));
                  state_nxt = S_POP;
                end
              end
            end
            lse_pkg::MODE_REPLACE: begin
              done = 1'b1;
              if (count_r == '0) begin
                status = lse_pkg::ST_UNDER;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_r - CW'(1));
                top_nxt = value_i;
                if (count_r == CW'(1)) begin
                  bottom_nxt = value_i;
                end
              end
            end
            lse_pkg::MODE_SEARCH: begin
              if (count_r == '0) begin
                done = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                state_nxt = S_SEARCH;
              end
            end
            lse_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              done      = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        top_nxt   = rd_data;
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        // rd_data holds the entry at addr_r, walking from top to bottom
        if (rd_data == key_r) begin
          found     = count_r - CW'(addr_r);
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else if (addr_r == '0) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_r - AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rd_en) begin
      addr_nxt = rd_addr;
    end
  end

  always_comb begin
    res_o.top    = (count_nxt == '0) ? '0 : top_nxt;
    res_o.bottom = (count_nxt == '0) ? '1 : bottom_nxt;
    res_o.count  = lse_pkg::RCOUNT_W'(count_nxt);
    res_o.empty  = (count_nxt == '0);
    res_o.found  = lse_pkg::RCOUNT_W'(found);
    res_o.status = status;
  end

  assign idle_o = (state_r == S_IDLE);
  assign done_o = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    key_r    <= key_nxt;
    addr_r   <= addr_nxt;
  end

  `LSE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(STACK_DEPTH), "fill count above depth")
  `LSE_ASSERT_IMPL(a_search_read, state_r == S_SEARCH, $past(rd_en), "search without read")
  `LSE_ASSERT_IMPL(a_wr_in_range, wr_en, CW'(wr_addr) <= count_r, "write beyond fill count")
  `LSE_ASSERT_NEXT(a_wr_nonempty, wr_en, count_r != '0, "write left stack empty")
  `LSE_ASSERT_NEXT(a_done_idle, done && (state_r != S_IDLE), state_r == S_IDLE, "not idle")

endmodule

### rtl/core/lifo_stack_engine_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_engine_core
// last-in first-out stack of 32-bit words with push, pop, replace, search, clear
// ----------------------------------------------------------------------------
// Each request gives one result carrying top, bottom, count, empty flag,
// search position and status. Push, replace, clear, unused modes, underflow,
// overflow and a pop that empties the stack complete in the cycle they are
// taken; any other pop also passes through S_POP, for one read of the new top
// from the word store. A search walks the store from the top, one word per
// cycle through the single read port, and stops at the nearest match or
// after the bottom word. The store needs no clearing pass: the fill count
// alone decides what is valid. A new request is taken in the cycle after a
// result is registered, as soon as the output slot is free.
module lifo_stack_engine_core #(
  parameter int unsigned STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lse_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [lse_pkg::MODE_W-1:0]      in_tuser,   // [2:0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] top_value, [63:32] bottom_value, [72:64] count, [73] empty_res,
  // [82:74] found_position, [84:83] status, [87:85] zero
  output logic [lse_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                           ctrl_idle;
  logic                           ctrl_done;
  logic                           start;
  lse_pkg::lse_res_t              res;
  logic                           out_valid_r;
  logic [lse_pkg::OUT_DATA_W-1:0] out_data_r;

  // take a request only when the sequencer is idle and the output slot frees
  assign in_tready = ctrl_idle && (!out_valid_r || out_tready);
  assign start     = in_tvalid && in_tready;

  lse_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .mode_i  (in_tuser),
    .value_i (in_tdata),
    .idle_o  (ctrl_idle),
    .done_o  (ctrl_done),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_done) begin
      out_data_r <= {3'b000, res.status, res.found, res.empty, res.count,
                     res.bottom, res.top};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
